/* sv/d2s_pkg.sv */
// Shared types, widths and register codes for the depth-to-space address generator.
`timescale 1ns / 1ps

package d2s_pkg;

	localparam int DEF_ADDR_BITS = 32;
	localparam int DEF_MAX_BLOCK = 16;

	localparam int BLK_CFG_W = 5;
	localparam int BATCH_W   = 13;
	localparam int CHAN_W    = 16;
	localparam int DIM_W     = 13;
	localparam int IDX_OUT_W = 32;
	localparam int DATA_W    = 32;
	localparam int PADDR_W   = 5;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_BLOCK_SIZE  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_ORDER_MODE  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_BATCH_COUNT = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_IN_CHANNELS = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_IN_HEIGHT   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_IN_WIDTH    = 3'd5;

	typedef struct packed {
		logic [BLK_CFG_W-1:0] block_size;
		logic                 order_mode;
		logic [BATCH_W-1:0]   batch_count;
		logic [CHAN_W-1:0]    in_channels;
		logic [DIM_W-1:0]     in_height;
		logic [DIM_W-1:0]     in_width;
	} d2s_cfg_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_LD_C2,
		ST_DIV_C2,
		ST_LD_H,
		ST_DIV_H,
		ST_LD_W,
		ST_DIV_W,
		ST_CHECK,
		ST_BLK,
		ST_IC,
		ST_S1,
		ST_S2,
		ST_S3,
		ST_D1,
		ST_D2,
		ST_D3,
		ST_OUT
	} d2s_state_t;

	typedef enum logic [1:0] {
		DIV_C2,
		DIV_H,
		DIV_W
	} div_sel_t;

	typedef enum logic [2:0] {
		MAC_BLK,
		MAC_IC,
		MAC_S1,
		MAC_S2,
		MAC_S3,
		MAC_D1,
		MAC_D2,
		MAC_D3
	} mac_op_t;

	typedef struct packed {
		logic     take_in;
		logic     load_derived;
		logic     div_start;
		logic     div_take;
		div_sel_t div_sel;
		logic     chk;
		logic     mac_en;
		mac_op_t  mac_op;
		logic     out_load;
	} d2s_cmd_t;

	typedef struct packed {
		logic div_done;
		logic empty;
		logic out_free;
	} d2s_sts_t;

endpackage

/* sv/depth_to_space_address_gen_top.sv */
// Depth-to-space address generator top level: APB registers, controller and datapath.
// Each transfer runs the check, eight passes through the one multiply-add and the output
// state (an empty tensor goes from check straight to output); the input stays stalled until
// the result is loaded. The first item after reset or a register write first runs three serial
// divisions of width MBW = max(13 + clog2(MAX_BLOCK+1), 16).
// Reset: registers return to 1 (order_mode 0), position counters to the first element.
`timescale 1ns / 1ps

module depth_to_space_address_gen_top #(
	parameter int ADDR_BITS = d2s_pkg::DEF_ADDR_BITS,
	parameter int MAX_BLOCK = d2s_pkg::DEF_MAX_BLOCK
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [d2s_pkg::PADDR_W-1:0]   paddr,
	input  logic [d2s_pkg::DATA_W-1:0]    pwdata,
	output logic [d2s_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          restart,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [d2s_pkg::IDX_OUT_W-1:0] src_index,
	output logic [d2s_pkg::IDX_OUT_W-1:0] dst_index,
	output logic                          valid_res,
	output logic                          last
);

	import d2s_pkg::*;

	// Register file. Writes land in the access phase; the port never waits.
	d2s_cfg_t              cfg_q;
	logic                  cfg_wr;
	logic [REG_IDX_W-1:0]  reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.block_size  <= BLK_CFG_W'(1);
			cfg_q.order_mode  <= 1'b0;
			cfg_q.batch_count <= BATCH_W'(1);
			cfg_q.in_channels <= CHAN_W'(1);
			cfg_q.in_height   <= DIM_W'(1);
			cfg_q.in_width    <= DIM_W'(1);
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_BLOCK_SIZE:  cfg_q.block_size  <= pwdata[BLK_CFG_W-1:0];
				REG_ORDER_MODE:  cfg_q.order_mode  <= pwdata[0];
				REG_BATCH_COUNT: cfg_q.batch_count <= pwdata[BATCH_W-1:0];
				REG_IN_CHANNELS: cfg_q.in_channels <= pwdata[CHAN_W-1:0];
				REG_IN_HEIGHT:   cfg_q.in_height   <= pwdata[DIM_W-1:0];
				REG_IN_WIDTH:    cfg_q.in_width    <= pwdata[DIM_W-1:0];
				default:         ;
			endcase
		end
	end

	// Readback of the stored values; unused addresses read as zero.
	always_comb begin
		case (reg_idx)
			REG_BLOCK_SIZE:  prdata = DATA_W'(cfg_q.block_size);
			REG_ORDER_MODE:  prdata = DATA_W'(cfg_q.order_mode);
			REG_BATCH_COUNT: prdata = DATA_W'(cfg_q.batch_count);
			REG_IN_CHANNELS: prdata = DATA_W'(cfg_q.in_channels);
			REG_IN_HEIGHT:   prdata = DATA_W'(cfg_q.in_height);
			REG_IN_WIDTH:    prdata = DATA_W'(cfg_q.in_width);
			default:         prdata = '0;
		endcase
	end

	// The controller marks derived sizes stale on any write and rebuilds them
	// (output channels, block edge, output extents, and the block split of the
	// current row and column) before the next item is worked on.
	d2s_cmd_t cmd;
	d2s_sts_t sts;

	d2s_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.cfg_wr   (cfg_wr),
		.sts      (sts),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	// The datapath holds the result in its own register, so the next transfer
	// is taken while a finished pair still waits downstream.
	d2s_dp #(
		.ADDR_BITS (ADDR_BITS),
		.MAX_BLOCK (MAX_BLOCK)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (cmd),
		.sts       (sts),
		.restart   (restart),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.src_index (src_index),
		.dst_index (dst_index),
		.valid_res (valid_res),
		.last      (last)
	);

endmodule

/* sv/d2s_div.sv */
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module d2s_div #(
	parameter int W = 18
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quot,
	output logic [W-1:0] rem
);

	localparam int CW = $clog2(W + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  quot_q;
	logic [W-1:0]  dvs_q;
	logic [W:0]    r_sh;
	logic [W:0]    r_sub;
	logic          ge;

	always_comb begin
		r_sh  = {rem_q, quot_q[W-1]};
		r_sub = r_sh - {1'b0, dvs_q};
		ge    = (r_sh >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quot_q <= dividend;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			rem_q  <= ge ? r_sub[W-1:0] : r_sh[W-1:0];
			quot_q <= {quot_q[W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

/* sv/d2s_dp.sv */
// Datapath: derived sizes, position counters, shared multiply-add and result register.
`timescale 1ns / 1ps

module d2s_dp #(
	parameter int ADDR_BITS = d2s_pkg::DEF_ADDR_BITS,
	parameter int MAX_BLOCK = d2s_pkg::DEF_MAX_BLOCK
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  d2s_pkg::d2s_cfg_t              cfg,
	input  d2s_pkg::d2s_cmd_t              cmd,
	output d2s_pkg::d2s_sts_t              sts,
	input  logic                           restart,
	input  logic                           out_stall,
	output logic                           out_valid,
	output logic [d2s_pkg::IDX_OUT_W-1:0]  src_index,
	output logic [d2s_pkg::IDX_OUT_W-1:0]  dst_index,
	output logic                           valid_res,
	output logic                           last
);

	import d2s_pkg::*;

	localparam int BW    = $clog2(MAX_BLOCK + 1);
	localparam int B2W   = 2 * BW;
	localparam int OHW   = DIM_W + BW;
	localparam int MBW   = (OHW > CHAN_W) ? OHW : CHAN_W;
	localparam int IDX_W = (ADDR_BITS < IDX_OUT_W) ? ADDR_BITS : IDX_OUT_W;

	// effective block edge, clamped to 1..MAX_BLOCK
	logic [BLK_CFG_W-1:0] bs_nz;
	logic [BW-1:0]        b_eff;
	logic [B2W-1:0]       b2_eff;
	logic [OHW-1:0]       oh_eff;
	logic [OHW-1:0]       ow_eff;

	always_comb begin
		bs_nz  = (cfg.block_size == '0) ? BLK_CFG_W'(1) : cfg.block_size;
		b_eff  = (int'(bs_nz) > MAX_BLOCK) ? BW'(MAX_BLOCK) : BW'(bs_nz);
		b2_eff = B2W'(b_eff) * B2W'(b_eff);
		oh_eff = OHW'(cfg.in_height) * OHW'(b_eff);
		ow_eff = OHW'(cfg.in_width) * OHW'(b_eff);
	end

	logic [BW-1:0]     b_q;
	logic [B2W-1:0]    b2_q;
	logic [OHW-1:0]    oh_q;
	logic [OHW-1:0]    ow_q;
	logic [CHAN_W-1:0] c2_q;

	// divider: channel split, then re-split of row and column into block parts
	logic [MBW-1:0] div_dividend;
	logic [MBW-1:0] div_divisor;
	logic           div_done;
	logic [MBW-1:0] div_quot;
	logic [MBW-1:0] div_rem;

	// output position and its split into input position and block offset
	logic [BATCH_W-1:0] n_q;
	logic [CHAN_W-1:0]  c_q;
	logic [OHW-1:0]     h_q;
	logic [OHW-1:0]     w_q;
	logic [DIM_W-1:0]   ih_q;
	logic [DIM_W-1:0]   iw_q;
	logic [BW-1:0]      bh_q;
	logic [BW-1:0]      bw_q;
	logic               restart_q;

	logic [BATCH_W:0] n_inc;
	logic [CHAN_W:0]  c_inc;
	logic [OHW:0]     h_inc;
	logic [OHW:0]     w_inc;
	logic [BW:0]      bh_inc;
	logic [BW:0]      bw_inc;
	logic             empty;
	logic             oor;
	logic             is_last;

	always_ff @(posedge clk) begin
		if (cmd.load_derived) begin
			b_q  <= b_eff;
			b2_q <= b2_eff;
			oh_q <= oh_eff;
			ow_q <= ow_eff;
		end
		if (cmd.div_take && (cmd.div_sel == DIV_C2)) begin
			c2_q <= CHAN_W'(div_quot);
		end
	end

	always_comb begin
		case (cmd.div_sel)
			DIV_C2: begin
				div_dividend = MBW'(cfg.in_channels);
				div_divisor  = MBW'(b2_eff);
			end
			DIV_H: begin
				div_dividend = MBW'(h_q);
				div_divisor  = MBW'(b_q);
			end
			DIV_W: begin
				div_dividend = MBW'(w_q);
				div_divisor  = MBW'(b_q);
			end
			default: begin
				div_dividend = '0;
				div_divisor  = MBW'(1);
			end
		endcase
	end

	d2s_div #(
		.W(MBW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	always_comb begin
		n_inc  = {1'b0, n_q} + (BATCH_W + 1)'(1);
		c_inc  = {1'b0, c_q} + (CHAN_W + 1)'(1);
		h_inc  = {1'b0, h_q} + (OHW + 1)'(1);
		w_inc  = {1'b0, w_q} + (OHW + 1)'(1);
		bh_inc = {1'b0, bh_q} + (BW + 1)'(1);
		bw_inc = {1'b0, bw_q} + (BW + 1)'(1);
		empty  = (c2_q == '0) || (cfg.batch_count == '0) || (oh_q == '0) || (ow_q == '0);
		oor    = (n_q >= cfg.batch_count) || (c_q >= c2_q) || (h_q >= oh_q) || (w_q >= ow_q);
		is_last = (n_inc == {1'b0, cfg.batch_count}) && (c_inc == {1'b0, c2_q}) &&
		          (h_inc == {1'b0, oh_q}) && (w_inc == {1'b0, ow_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q       <= '0;
			c_q       <= '0;
			h_q       <= '0;
			w_q       <= '0;
			ih_q      <= '0;
			iw_q      <= '0;
			bh_q      <= '0;
			bw_q      <= '0;
			restart_q <= 1'b0;
		end else begin
			if (cmd.take_in) begin
				restart_q <= restart;
			end
			if (cmd.div_take && (cmd.div_sel == DIV_H)) begin
				ih_q <= DIM_W'(div_quot);
				bh_q <= BW'(div_rem);
			end
			if (cmd.div_take && (cmd.div_sel == DIV_W)) begin
				iw_q <= DIM_W'(div_quot);
				bw_q <= BW'(div_rem);
			end
			if (cmd.chk && !empty && (restart_q || oor)) begin
				n_q  <= '0;
				c_q  <= '0;
				h_q  <= '0;
				w_q  <= '0;
				ih_q <= '0;
				iw_q <= '0;
				bh_q <= '0;
				bw_q <= '0;
			end else if (cmd.out_load && !empty) begin
				if (w_inc < {1'b0, ow_q}) begin
					w_q <= w_inc[OHW-1:0];
					if (bw_inc == {1'b0, b_q}) begin
						bw_q <= '0;
						iw_q <= iw_q + DIM_W'(1);
					end else begin
						bw_q <= bw_inc[BW-1:0];
					end
				end else begin
					w_q  <= '0;
					bw_q <= '0;
					iw_q <= '0;
					if (h_inc < {1'b0, oh_q}) begin
						h_q <= h_inc[OHW-1:0];
						if (bh_inc == {1'b0, b_q}) begin
							bh_q <= '0;
							ih_q <= ih_q + DIM_W'(1);
						end else begin
							bh_q <= bh_inc[BW-1:0];
						end
					end else begin
						h_q  <= '0;
						bh_q <= '0;
						ih_q <= '0;
						if (c_inc < {1'b0, c2_q}) begin
							c_q <= c_inc[CHAN_W-1:0];
						end else begin
							c_q <= '0;
							n_q <= (n_inc < {1'b0, cfg.batch_count}) ? n_inc[BATCH_W-1:0] : '0;
						end
					end
				end
			end
		end
	end

	// shared multiply-add, one product per cycle
	logic [IDX_W-1:0]     mul_a;
	logic [MBW-1:0]       mul_b;
	logic [IDX_W-1:0]     mul_add;
	logic [IDX_W+MBW-1:0] prod;
	logic [IDX_W-1:0]     mac_res;
	logic [IDX_W-1:0]     tmp_q;
	logic [IDX_W-1:0]     src_q;
	logic [IDX_W-1:0]     dst_q;

	always_comb begin
		case (cmd.mac_op)
			MAC_BLK: begin
				mul_a   = IDX_W'(bh_q);
				mul_b   = MBW'(b_q);
				mul_add = IDX_W'(bw_q);
			end
			MAC_IC: begin
				if (cfg.order_mode) begin
					mul_a   = IDX_W'(c_q);
					mul_b   = MBW'(b2_q);
					mul_add = tmp_q;
				end else begin
					mul_a   = tmp_q;
					mul_b   = MBW'(c2_q);
					mul_add = IDX_W'(c_q);
				end
			end
			MAC_S1: begin
				mul_a   = IDX_W'(n_q);
				mul_b   = MBW'(cfg.in_channels);
				mul_add = tmp_q;
			end
			MAC_S2: begin
				mul_a   = src_q;
				mul_b   = MBW'(cfg.in_height);
				mul_add = IDX_W'(ih_q);
			end
			MAC_S3: begin
				mul_a   = src_q;
				mul_b   = MBW'(cfg.in_width);
				mul_add = IDX_W'(iw_q);
			end
			MAC_D1: begin
				mul_a   = IDX_W'(n_q);
				mul_b   = MBW'(c2_q);
				mul_add = IDX_W'(c_q);
			end
			MAC_D2: begin
				mul_a   = dst_q;
				mul_b   = MBW'(oh_q);
				mul_add = IDX_W'(h_q);
			end
			MAC_D3: begin
				mul_a   = dst_q;
				mul_b   = MBW'(ow_q);
				mul_add = IDX_W'(w_q);
			end
			default: begin
				mul_a   = '0;
				mul_b   = '0;
				mul_add = '0;
			end
		endcase
		prod    = (IDX_W + MBW)'(mul_a) * (IDX_W + MBW)'(mul_b);
		mac_res = prod[IDX_W-1:0] + mul_add;
	end

	always_ff @(posedge clk) begin
		if (cmd.mac_en) begin
			case (cmd.mac_op)
				MAC_BLK, MAC_IC:         tmp_q <= mac_res;
				MAC_S1, MAC_S2, MAC_S3:  src_q <= mac_res;
				MAC_D1, MAC_D2, MAC_D3:  dst_q <= mac_res;
				default:                 tmp_q <= mac_res;
			endcase
		end
	end

	// result register
	logic                 out_valid_q;
	logic [IDX_OUT_W-1:0] src_index_q;
	logic [IDX_OUT_W-1:0] dst_index_q;
	logic                 valid_res_q;
	logic                 last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (empty) begin
				src_index_q <= '0;
				dst_index_q <= '0;
				valid_res_q <= 1'b0;
				last_q      <= 1'b0;
			end else begin
				src_index_q <= IDX_OUT_W'(src_q);
				dst_index_q <= IDX_OUT_W'(dst_q);
				valid_res_q <= 1'b1;
				last_q      <= is_last;
			end
		end
	end

	always_comb begin
		sts.div_done = div_done;
		sts.empty    = empty;
		sts.out_free = !out_valid_q || !out_stall;
	end

	assign out_valid = out_valid_q;
	assign src_index = src_index_q;
	assign dst_index = dst_index_q;
	assign valid_res = valid_res_q;
	assign last      = last_q;

endmodule

/* sv/d2s_ctrl.sv */
// Controller: sequences size derivation, index arithmetic and result hand-off.
`timescale 1ns / 1ps

module d2s_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              cfg_wr,
	input  d2s_pkg::d2s_sts_t sts,
	output d2s_pkg::d2s_cmd_t cmd,
	output logic              in_stall
);

	import d2s_pkg::*;

	d2s_state_t state_q;
	d2s_state_t state_d;
	logic       dirty_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dirty_q <= 1'b1;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				dirty_q <= 1'b1;
			end else if ((state_q == ST_DIV_W) && sts.div_done) begin
				dirty_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_valid) state_d = dirty_q ? ST_LD_C2 : ST_CHECK;
			ST_LD_C2:  state_d = ST_DIV_C2;
			ST_DIV_C2: if (sts.div_done) state_d = ST_LD_H;
			ST_LD_H:   state_d = ST_DIV_H;
			ST_DIV_H:  if (sts.div_done) state_d = ST_LD_W;
			ST_LD_W:   state_d = ST_DIV_W;
			ST_DIV_W:  if (sts.div_done) state_d = ST_CHECK;
			ST_CHECK:  state_d = sts.empty ? ST_OUT : ST_BLK;
			ST_BLK:    state_d = ST_IC;
			ST_IC:     state_d = ST_S1;
			ST_S1:     state_d = ST_S2;
			ST_S2:     state_d = ST_S3;
			ST_S3:     state_d = ST_D1;
			ST_D1:     state_d = ST_D2;
			ST_D2:     state_d = ST_D3;
			ST_D3:     state_d = ST_OUT;
			ST_OUT:    if (sts.out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.div_sel = DIV_C2;
		cmd.mac_op  = MAC_BLK;
		case (state_q)
			ST_IDLE: cmd.take_in = in_valid;
			ST_LD_C2: begin
				cmd.load_derived = 1'b1;
				cmd.div_start    = 1'b1;
			end
			ST_DIV_C2: cmd.div_take = sts.div_done;
			ST_LD_H: begin
				cmd.div_sel   = DIV_H;
				cmd.div_start = 1'b1;
			end
			ST_DIV_H: begin
				cmd.div_sel  = DIV_H;
				cmd.div_take = sts.div_done;
			end
			ST_LD_W: begin
				cmd.div_sel   = DIV_W;
				cmd.div_start = 1'b1;
			end
			ST_DIV_W: begin
				cmd.div_sel  = DIV_W;
				cmd.div_take = sts.div_done;
			end
			ST_CHECK: cmd.chk = 1'b1;
			ST_BLK: cmd.mac_en = 1'b1;
			ST_IC: begin
				cmd.mac_en = 1'b1;
				cmd.mac_op = MAC_IC;
			end
			ST_S1: begin
				cmd.mac_en = 1'b1;
				cmd.mac_op = MAC_S1;
			end
			ST_S2: begin
				cmd.mac_en = 1'b1;
				cmd.mac_op = MAC_S2;
			end
			ST_S3: begin
				cmd.mac_en = 1'b1;
				cmd.mac_op = MAC_S3;
			end
			ST_D1: begin
				cmd.mac_en = 1'b1;
				cmd.mac_op = MAC_D1;
			end
			ST_D2: begin
				cmd.mac_en = 1'b1;
				cmd.mac_op = MAC_D2;
			end
			ST_D3: begin
				cmd.mac_en = 1'b1;
				cmd.mac_op = MAC_D3;
			end
			ST_OUT: cmd.out_load = sts.out_free;
			default: cmd = '0;
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

/* sv/d2s_chk.sv */
// Port-level checker for the depth-to-space address generator, bound to the top level.
`timescale 1ns / 1ps

module d2s_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [d2s_pkg::IDX_OUT_W-1:0] src_index,
	input logic [d2s_pkg::IDX_OUT_W-1:0] dst_index,
	input logic                          valid_res,
	input logic                          last
);

	// one item in flight: a transfer closes the input until its work is done
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken twice in a row");

	// an empty-tensor result carries all-zero fields
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !valid_res) |-> ((src_index == '0) && (dst_index == '0) && !last))
		else $error("empty result with nonzero fields");

	// a last flag only on a meaningful pair
	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last) |-> valid_res)
		else $error("last flag on an invalid pair");

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("result dropped while stalled");

endmodule

bind depth_to_space_address_gen_top d2s_chk u_chk (.*);
